@@ hdl/fpa_pkg.sv @@
// fpa_pkg: shared types and constants for the fixed-point alu
// holds operation codes, status codes, queue entry and pipeline word types
// no dependencies
package fpa_pkg;

  // default number of fractional bits (q24.8)
  localparam int FRAC_BITS_DEF = 8;
  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  // quotient bits produced by the divider steps
  localparam int QUO_BITS = 33;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4,
    OP_DEC = 3'd5,
    OP_MIN = 3'd6,
    OP_MAX = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN = 32'h8000_0000;

  // classified word handed from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        neg;
    logic        divz;
    logic        less;
    logic        equal;
    logic        greater;
  } fe_t;

  // word carried down the back pipeline
  typedef struct packed {
    op_t         op;
    logic        neg;
    logic        divz;
    logic        less;
    logic        equal;
    logic        greater;
    logic        ovf;
    logic [31:0] res;
    logic [1:0]  status;
    logic [31:0] den;
    logic [31:0] rem;
    logic [QUO_BITS-1:0] quo;
    logic [QUO_BITS-1:0] nlo;
  } pipe_t;

endpackage

@@ hdl/fixed_point_alu.sv @@
// fixed_point_alu: signed fixed-point alu, one word accepted per cycle while busy is low
// path: front register, queue, issue register, divider steps, output register; every op takes it
// throughput: one word per cycle while busy is low; every stage is pipelined, the 33-stage divider sets latency
// busy only rises if the front/back queue nears full, which a free-running back never lets happen
// reset: synchronous active-low rst_n clears all valid flags and queue pointers
// depends on fpa_pkg, fpa_front, fpa_queue, fpa_back
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic               out_less,
  output logic               out_equal,
  output logic               out_greater,
  output logic [1:0]         out_status
);

  logic push;
  fe_t  push_data;
  logic pop;
  fe_t  pop_data;
  logic [31:0] res;

  // front: accept and classify
  fpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .push         (push),
    .push_data    (push_data)
  );

  // queue between front and back
  fpa_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_data   (push_data),
    .pop         (pop),
    .pop_data    (pop_data),
    .almost_full (busy)
  );

  // back: execution pipeline
  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (pop),
    .in_data     (pop_data),
    .out_valid   (out_valid),
    .out_result  (res),
    .out_less    (out_less),
    .out_equal   (out_equal),
    .out_greater (out_greater),
    .out_status  (out_status)
  );

  assign out_result = res;

endmodule

@@ hdl/fpa_front.sv @@
// fpa_front: accepts command words and classifies them
// depends on fpa_pkg
module fpa_front import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               push,
  output fe_t                push_data
);

  logic vld_r;
  fe_t  ent_r;
  fe_t  ent_nxt;

  // classify: magnitudes, result sign, zero-divisor flag, compare flags
  always_comb begin
    ent_nxt.op      = op_t'(in_operation);
    ent_nxt.a       = in_operand_a;
    ent_nxt.b       = in_operand_b;
    ent_nxt.mag_a   = in_operand_a[31] ? 32'(-in_operand_a) : in_operand_a;
    ent_nxt.mag_b   = in_operand_b[31] ? 32'(-in_operand_b) : in_operand_b;
    ent_nxt.neg     = in_operand_a[31] ^ in_operand_b[31];
    ent_nxt.divz    = (in_operand_b == 32'sd0);
    ent_nxt.less    = (in_operand_a < in_operand_b);
    ent_nxt.equal   = (in_operand_a == in_operand_b);
    ent_nxt.greater = (in_operand_a > in_operand_b);
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ent_r <= ent_nxt;
    end
  end

  assign push      = vld_r;
  assign push_data = ent_r;

endmodule

@@ hdl/fpa_queue.sv @@
// fpa_queue: short fifo between front and back
// depends on fpa_pkg
module fpa_queue import fpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  fe_t  push_data,
  output logic pop,
  output fe_t  pop_data,
  output logic almost_full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fe_t           mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;

  // back never stalls, so pop whenever a word waits
  assign pop         = (cnt_r != '0);
  assign pop_data    = mem_r[rd_r];
  assign almost_full = (cnt_r >= CW'(QUEUE_DEPTH - 1));

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= PW'(wr_r + 1'b1);
      end
      if (pop) begin
        rd_r <= PW'(rd_r + 1'b1);
      end
      cnt_r <= CW'(cnt_r + CW'(push) - CW'(pop));
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

@@ hdl/fpa_back.sv @@
// fpa_back: execution pipeline: simple ops, multiplier, bit-per-stage divider
// depends on fpa_pkg
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  fe_t         in_data,
  output logic        out_valid,
  output logic [31:0] out_result,
  output logic        out_less,
  output logic        out_equal,
  output logic        out_greater,
  output logic [1:0]  out_status
);

  localparam int NSTEP = QUO_BITS;

  pipe_t       st_r   [NSTEP+1];
  pipe_t       iss_nxt;
  pipe_t       st_nxt [1:NSTEP];
  logic        vld_r  [NSTEP+1];
  logic [63:0] prod_r;

  logic [63:0] num;
  logic [32:0] sum;
  logic [31:0] lo_res;
  logic [1:0]  lo_st;

  // issue stage: simple ops, divider setup
  always_comb begin
    num    = 64'(in_data.mag_a) << FRAC_BITS;
    sum    = '0;
    lo_res = '0;
    lo_st  = ST_OK;
    case (in_data.op)
      OP_ADD: sum = {in_data.a[31], in_data.a} + {in_data.b[31], in_data.b};
      OP_SUB: sum = {in_data.a[31], in_data.a} - {in_data.b[31], in_data.b};
      OP_INC: sum = {in_data.a[31], in_data.a} + 33'd1;
      OP_DEC: sum = {in_data.a[31], in_data.a} - 33'd1;
      default: sum = '0;
    endcase
    case (in_data.op)
      OP_MIN: lo_res = in_data.less ? in_data.a : in_data.b;
      OP_MAX: lo_res = in_data.greater ? in_data.a : in_data.b;
      default: begin
        if (sum[32] != sum[31]) begin
          lo_res = sum[32] ? RAW_MIN : RAW_MAX;
          lo_st  = ST_SAT;
        end else begin
          lo_res = sum[31:0];
        end
      end
    endcase
    iss_nxt.op      = in_data.op;
    iss_nxt.neg     = in_data.neg;
    iss_nxt.divz    = in_data.divz;
    iss_nxt.less    = in_data.less;
    iss_nxt.equal   = in_data.equal;
    iss_nxt.greater = in_data.greater;
    iss_nxt.res     = lo_res;
    iss_nxt.status  = lo_st;
    iss_nxt.den     = in_data.mag_b;
    iss_nxt.rem     = {1'b0, num[63:33]};
    iss_nxt.ovf     = ({1'b0, num[63:33]} >= in_data.mag_b);
    iss_nxt.quo     = '0;
    iss_nxt.nlo     = num[32:0];
  end

  // divider steps, one quotient bit each; step one also finishes multiply
  always_comb begin
    logic [32:0] t;
    logic        ge;
    logic [63:0] mq;
    mq = '0;
    for (int i = 1; i <= NSTEP; i++) begin
      st_nxt[i] = st_r[i-1];
      t  = {st_r[i-1].rem, st_r[i-1].nlo[QUO_BITS-1]};
      ge = (t >= {1'b0, st_r[i-1].den});
      st_nxt[i].rem = ge ? 32'(t - {1'b0, st_r[i-1].den}) : t[31:0];
      st_nxt[i].quo = {st_r[i-1].quo[QUO_BITS-2:0], ge};
      st_nxt[i].nlo = {st_r[i-1].nlo[QUO_BITS-2:0], 1'b0};
      if (i == 1 && st_r[0].op == OP_MUL) begin
        mq = (prod_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (mq > (st_r[0].neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
          st_nxt[i].res    = st_r[0].neg ? RAW_MIN : RAW_MAX;
          st_nxt[i].status = ST_SAT;
        end else begin
          st_nxt[i].res    = st_r[0].neg ? 32'(-mq[31:0]) : mq[31:0];
          st_nxt[i].status = ST_OK;
        end
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    st_r[0] <= iss_nxt;
    for (int i = 1; i <= NSTEP; i++) begin
      st_r[i] <= st_nxt[i];
    end
    prod_r <= in_data.mag_a * in_data.mag_b;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NSTEP; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= NSTEP; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // final stage: divide rounding and saturation
  pipe_t       fin;
  logic        rnd;
  logic [33:0] dq;
  logic [31:0] res_nxt;
  logic [1:0]  st_code_nxt;

  always_comb begin
    fin         = st_r[NSTEP];
    rnd         = ({fin.rem, 1'b0} >= {1'b0, fin.den});
    dq          = 34'(fin.quo) + 34'(rnd);
    res_nxt     = fin.res;
    st_code_nxt = fin.status;
    if (fin.op == OP_DIV) begin
      if (fin.divz) begin
        res_nxt     = '0;
        st_code_nxt = ST_DIVZ;
      end else if (fin.ovf || dq > (fin.neg ? 34'h8000_0000 : 34'h7FFF_FFFF)) begin
        res_nxt     = fin.neg ? RAW_MIN : RAW_MAX;
        st_code_nxt = ST_SAT;
      end else begin
        res_nxt     = fin.neg ? 32'(-dq[31:0]) : dq[31:0];
        st_code_nxt = ST_OK;
      end
    end
  end

  logic        ov_r;
  logic [31:0] ores_r;
  logic        oless_r;
  logic        oeq_r;
  logic        ogt_r;
  logic [1:0]  ost_r;

  // output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vld_r[NSTEP];
    end
  end

  // output word
  always_ff @(posedge clk) begin
    ores_r  <= res_nxt;
    oless_r <= fin.less;
    oeq_r   <= fin.equal;
    ogt_r   <= fin.greater;
    ost_r   <= st_code_nxt;
  end

  assign out_valid   = ov_r;
  assign out_result  = ores_r;
  assign out_less    = oless_r;
  assign out_equal   = oeq_r;
  assign out_greater = ogt_r;
  assign out_status  = ost_r;

endmodule

@@ verif/tb_fixed_point_alu.sv @@
// tb_fixed_point_alu: self-checking testbench for the fixed-point alu
// predicts every result word in 64-bit arithmetic and checks each strobed word in order
// depends on fpa_pkg and fixed_point_alu
module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] result;
    logic        less;
    logic        equal;
    logic        greater;
    logic [1:0]  status;
  } alu_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_operation = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic               out_valid;
  logic signed [31:0] out_result;
  logic               out_less;
  logic               out_equal;
  logic               out_greater;
  logic [1:0]         out_status;

  alu_word_t expected_words[$];
  int        mismatch_count = 0;

  fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .out_valid(out_valid), .out_result(out_result),
    .out_less(out_less), .out_equal(out_equal), .out_greater(out_greater),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  // clamp a wide value to the 32-bit raw range
  function automatic logic [31:0] clamp_raw(longint v, inout logic [1:0] st);
    if (v > 64'sd2147483647) begin
      st = ST_SAT;
      return RAW_MAX;
    end
    if (v < -64'sd2147483648) begin
      st = ST_SAT;
      return RAW_MIN;
    end
    return v[31:0];
  endfunction

  // expected word for one operation
  function automatic alu_word_t alu_predict(op_t op, logic signed [31:0] a,
                                            logic signed [31:0] b);
    alu_word_t w;
    longint    sa, sb, prod, r;
    longint unsigned mag, num, den, q;
    logic [1:0] st;
    sa = a;
    sb = b;
    st = ST_OK;
    r = 0;
    case (op)
      OP_ADD: r = sa + sb;
      OP_SUB: r = sa - sb;
      OP_MUL: begin
        prod = sa * sb;
        mag = (prod < 0) ? -prod : prod;
        q = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        r = (prod < 0) ? -longint'(q) : longint'(q);
      end
      OP_DIV: begin
        if (sb != 0) begin
          num = ((sa < 0) ? -sa : sa) << FRAC;
          den = (sb < 0) ? -sb : sb;
          q = (2 * num + den) / (2 * den);
          r = ((sa < 0) != (sb < 0)) ? -longint'(q) : longint'(q);
        end
      end
      OP_INC: r = sa + 1;
      OP_DEC: r = sa - 1;
      OP_MIN: r = (sa < sb) ? sa : sb;
      default: r = (sa > sb) ? sa : sb;
    endcase
    if (op == OP_DIV && sb == 0) begin
      w.result = '0;
      st = ST_DIVZ;
    end else begin
      w.result = clamp_raw(r, st);
    end
    w.status = st;
    w.less = sa < sb;
    w.equal = sa == sb;
    w.greater = sa > sb;
    return w;
  endfunction

  // drive one word, wait for acceptance, then an optional random gap
  task automatic send_word(op_t op, logic [31:0] a, logic [31:0] b, bit allow_gap = 1);
    int gap;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_words.push_back(alu_predict(op, a, b));
    @(negedge clk);
    gap = allow_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // operand mix with extremes and small values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 4095) - 2048;
      2: return {$urandom_range(0, 1) ? 32'h7FFF_FF00 : 32'h8000_0000} + $urandom_range(0, 255);
      3: return ($urandom() >> $urandom_range(0, 31));
      4: return -($urandom() >> $urandom_range(8, 31));
      default: return $urandom_range(0, 65535) << 8;
    endcase
  endfunction

  // compare each strobed word with the oldest expectation
  always @(posedge clk) begin
    alu_word_t e;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", out_result);
      end else begin
        e = expected_words.pop_front();
        if (out_result !== e.result || out_less !== e.less || out_equal !== e.equal ||
            out_greater !== e.greater || out_status !== e.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp r=%h l%b e%b g%b s%0d got r=%h l%b e%b g%b s%0d",
                     e.result, e.less, e.equal, e.greater, e.status, out_result,
                     out_less, out_equal, out_greater, out_status);
        end
      end
    end
  end

  task automatic test_extremes();
    logic [31:0] vals[5];
    vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, RAW_MAX, RAW_MIN};
    for (int i = 0; i < 8; i++)
      send_word(op_t'(i), vals[i % 5], vals[(i + 2) % 5]);
    send_word(OP_ADD, RAW_MAX, 32'h1);
    send_word(OP_SUB, RAW_MIN, 32'h1);
    send_word(OP_MUL, RAW_MIN, RAW_MIN);
    send_word(OP_MUL, 32'h180, 32'hFFFF_FF80);
    send_word(OP_DIV, 32'h1234, 32'h0);
    send_word(OP_DIV, RAW_MIN, 32'hFFFF_FFFF);
    send_word(OP_DIV, 32'h100, 32'h300);
    send_word(OP_INC, RAW_MAX, RAW_MAX);
    send_word(OP_DEC, RAW_MIN, RAW_MAX);
    send_word(OP_MIN, 32'h5, 32'h5);
    send_word(OP_MAX, RAW_MIN, RAW_MAX);
  endtask

  task automatic test_back_to_back();
    for (int i = 0; i < 64; i++)
      send_word(op_t'($urandom_range(0, 7)), rand_operand(), rand_operand(), 0);
  endtask

  task automatic test_random();
    logic [31:0] a;
    for (int i = 0; i < 1700; i++) begin
      a = rand_operand();
      send_word(op_t'($urandom_range(0, 7)), a,
                ($urandom_range(0, 9) == 0) ? a : rand_operand());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_back_to_back();
    test_random();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // overall time limit
  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
